FILE: hdl/vpfd_pkg.sv
// Shared constants, stage item types and saturation helper for the velocity PID block.
`timescale 1ns / 1ps

package vpfd_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE       = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN  = 3'd1;
  localparam logic [2:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [2:0] CFG_DERIV_POLE = 3'd3;
  localparam logic [2:0] CFG_DERIV_GAIN = 3'd4;
  localparam logic [2:0] CFG_LOWER      = 3'd5;
  localparam logic [2:0] CFG_UPPER      = 3'd6;

  // controller modes; the spare code acts as proportional only
  localparam logic [1:0] MODE_PID   = 2'd0;
  localparam logic [1:0] MODE_PI    = 2'd1;
  localparam logic [1:0] MODE_P     = 2'd2;
  localparam logic [1:0] MODE_P_ALT = 2'd3;

  // item actions
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  // after the difference stage
  typedef struct packed {
    logic               clear;
    logic               is_p;
    logic               is_pid;
    logic signed [32:0] err;
    logic signed [33:0] kp_op;   // error change, or error in P mode
    logic signed [32:0] dy;
  } diff_t;

  // after the product stage
  typedef struct packed {
    logic               clear;
    logic               is_p;
    logic               is_pid;
    logic signed [49:0] p_term;
    logic signed [48:0] i_term;
    logic signed [48:0] kd_term;
  } prod_t;

  // after the derivative filter stage
  typedef struct packed {
    logic               clear;
    logic               is_p;
    logic signed [49:0] p_term;
    logic signed [48:0] i_term;
    logic signed [32:0] dd;      // old filtered derivative minus new one
  } term_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/vpfd_front.sv
// Input stage: error, error change and measurement change, plus reference/measurement history.
`timescale 1ns / 1ps

module vpfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  logic                action_i,
  input  logic signed [31:0]  reference_i,
  input  logic signed [31:0]  measurement_i,
  output logic                dn_valid_o,
  output vpfd_pkg::diff_t     dn_item_o,
  input  logic                dn_ready_i
);

  logic                 valid_q;
  vpfd_pkg::diff_t      item_q, item_d;
  logic signed [31:0]   last_ref_q, last_meas_q;
  logic signed [32:0]   err, dy;
  logic signed [33:0]   derr;
  logic                 take, is_p;

  assign is_p       = (mode_i == vpfd_pkg::MODE_P) || (mode_i == vpfd_pkg::MODE_P_ALT);
  assign up_ready_o = !valid_q || dn_ready_i;
  assign take       = up_valid_i && up_ready_o;

  assign err  = reference_i - measurement_i;
  assign derr = err - last_ref_q + last_meas_q;
  assign dy   = measurement_i - last_meas_q;

  always_comb begin
    item_d.clear  = (action_i == vpfd_pkg::ACT_CLEAR);
    item_d.is_p   = is_p;
    item_d.is_pid = (mode_i == vpfd_pkg::MODE_PID);
    item_d.err    = err;
    item_d.kp_op  = is_p ? 34'(err) : derr;
    item_d.dy     = dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      last_ref_q  <= '0;
      last_meas_q <= '0;
    end else begin
      if (up_ready_o) begin
        valid_q <= up_valid_i;
      end
      if (take) begin
        if (action_i == vpfd_pkg::ACT_CLEAR) begin
          last_ref_q  <= '0;
          last_meas_q <= '0;
        end else if (!is_p) begin
          last_ref_q  <= reference_i;
          last_meas_q <= measurement_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_item_o  = item_q;

endmodule

FILE: hdl/vpfd_mult.sv
// Product stage: proportional, integral and derivative-input products in Q16.16, floored.
`timescale 1ns / 1ps

module vpfd_mult (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  prop_gain_i,
  input  logic signed [31:0]  integ_gain_dt_i,
  input  logic signed [31:0]  deriv_gain_i,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  vpfd_pkg::diff_t     up_item_i,
  output logic                dn_valid_o,
  output vpfd_pkg::prod_t     dn_item_o,
  input  logic                dn_ready_i
);

  logic                 valid_q;
  vpfd_pkg::prod_t      item_q, item_d;
  logic signed [65:0]   kp_prod;
  logic signed [64:0]   ki_prod, kd_prod;
  logic                 take;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign take       = up_valid_i && up_ready_o;

  assign kp_prod = prop_gain_i * up_item_i.kp_op;
  assign ki_prod = integ_gain_dt_i * up_item_i.err;
  assign kd_prod = deriv_gain_i * up_item_i.dy;

  // dropping the low 16 bits of a signed product floors it
  always_comb begin
    item_d.clear   = up_item_i.clear;
    item_d.is_p    = up_item_i.is_p;
    item_d.is_pid  = up_item_i.is_pid;
    item_d.p_term  = kp_prod[65:16];
    item_d.i_term  = ki_prod[64:16];
    item_d.kd_term = kd_prod[64:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_item_o  = item_q;

endmodule

FILE: hdl/vpfd_deriv.sv
// Derivative filter stage: first-order filter state update and derivative change.
`timescale 1ns / 1ps

module vpfd_deriv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [16:0]         deriv_pole_i,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  vpfd_pkg::prod_t     up_item_i,
  output logic                dn_valid_o,
  output vpfd_pkg::term_t     dn_item_o,
  input  logic                dn_ready_i
);

  logic                 valid_q;
  vpfd_pkg::term_t      item_q, item_d;
  logic signed [31:0]   last_deriv_q;
  logic signed [49:0]   pole_prod;
  logic signed [33:0]   pole_term;
  logic signed [51:0]   u_sum;
  logic signed [31:0]   ud;
  logic signed [32:0]   dd;
  logic                 take;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign take       = up_valid_i && up_ready_o;

  // filter loop closes here within the stage: pole * state + kd * dy, saturated
  assign pole_prod = $signed({1'b0, deriv_pole_i}) * last_deriv_q;
  assign pole_term = pole_prod[49:16];
  assign u_sum     = pole_term + up_item_i.kd_term;
  assign ud        = vpfd_pkg::sat32(u_sum);
  assign dd        = last_deriv_q - ud;

  always_comb begin
    item_d.clear  = up_item_i.clear;
    item_d.is_p   = up_item_i.is_p;
    item_d.p_term = up_item_i.p_term;
    item_d.i_term = up_item_i.i_term;
    item_d.dd     = up_item_i.is_pid ? dd : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      last_deriv_q <= '0;
    end else begin
      if (up_ready_o) begin
        valid_q <= up_valid_i;
      end
      if (take) begin
        if (up_item_i.clear) begin
          last_deriv_q <= '0;
        end else if (up_item_i.is_pid) begin
          last_deriv_q <= ud;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_item_o  = item_q;

endmodule

FILE: hdl/vpfd_accum.sv
// Output stage: velocity-form accumulation, clamp, last-output history and result register.
`timescale 1ns / 1ps

module vpfd_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  lower_limit_i,
  input  logic signed [31:0]  upper_limit_i,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  vpfd_pkg::term_t     up_item_i,
  output logic                out_valid_o,
  output logic signed [31:0]  drive_o,
  input  logic                out_stall_i
);

  logic                 valid_q;
  logic signed [31:0]   drive_q, drive_d;
  logic signed [31:0]   last_out_q;
  logic signed [51:0]   sum;
  logic signed [31:0]   clamped;
  logic                 take;

  assign up_ready_o = !valid_q || !out_stall_i;
  assign take       = up_valid_i && up_ready_o;

  assign sum = last_out_q + up_item_i.p_term + up_item_i.i_term + up_item_i.dd;

  // upper bound wins, also with crossed limits
  always_comb begin
    if (sum > upper_limit_i) begin
      clamped = upper_limit_i;
    end else if (sum < lower_limit_i) begin
      clamped = lower_limit_i;
    end else begin
      clamped = sum[31:0];
    end
  end

  always_comb begin
    if (up_item_i.clear) begin
      drive_d = '0;
    end else if (up_item_i.is_p) begin
      drive_d = vpfd_pkg::sat32(52'(up_item_i.p_term));
    end else begin
      drive_d = clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_out_q <= '0;
    end else begin
      if (up_ready_o) begin
        valid_q <= up_valid_i;
      end
      if (take && !up_item_i.is_p) begin
        last_out_q <= drive_d;
      end else if (take && up_item_i.clear) begin
        last_out_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = valid_q;
  assign drive_o     = drive_q;

endmodule

FILE: hdl/velocity_pid_filtered_derivative.sv
// Top level of the velocity-form PID controller with filtered derivative.
//
// Input channel: in_valid_i / in_stall_o carry one item (action, reference,
// measurement); accepted when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i carry one drive value per item.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i; write
// only while no item is in flight.
// Throughput is one item per clock while out_stall_i is low. An item passes four
// register stages (difference, product, derivative filter, accumulate/clamp),
// the first loaded at the accepting edge, and out_valid_o rises once the last
// of them holds the result. The filter state and the last output each close
// their loop within their own stage, which lets items follow back to back.
// Each stage holds its item until the next one has room, so while the result
// is stalled the block still takes items into empty stages; in_stall_o rises
// only when all four stages are full and out_stall_i is high.
// Reset clears all history and the pipeline; limits reset to the full 32-bit
// range and all other configuration registers to zero.
`timescale 1ns / 1ps

module velocity_pid_filtered_derivative (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic signed [31:0]  reference_i,
  input  logic signed [31:0]  measurement_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  drive_o
);

  logic [1:0]          mode_q;
  logic signed [31:0]  prop_gain_q, integ_gain_dt_q, deriv_gain_q;
  logic [16:0]         deriv_pole_q;
  logic signed [31:0]  lower_limit_q, upper_limit_q;

  logic                front_ready, mult_ready, deriv_ready, accum_ready;
  logic                front_valid, mult_valid, deriv_valid;
  vpfd_pkg::diff_t     front_item;
  vpfd_pkg::prod_t     mult_item;
  vpfd_pkg::term_t     deriv_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= vpfd_pkg::MODE_PID;
      prop_gain_q     <= '0;
      integ_gain_dt_q <= '0;
      deriv_pole_q    <= '0;
      deriv_gain_q    <= '0;
      lower_limit_q   <= 32'sh80000000;
      upper_limit_q   <= 32'sh7fffffff;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vpfd_pkg::CFG_MODE:       mode_q          <= cfg_wdata_i[1:0];
        vpfd_pkg::CFG_PROP_GAIN:  prop_gain_q     <= cfg_wdata_i;
        vpfd_pkg::CFG_INTEG_GAIN: integ_gain_dt_q <= cfg_wdata_i;
        vpfd_pkg::CFG_DERIV_POLE: deriv_pole_q    <= cfg_wdata_i[16:0];
        vpfd_pkg::CFG_DERIV_GAIN: deriv_gain_q    <= cfg_wdata_i;
        vpfd_pkg::CFG_LOWER:      lower_limit_q   <= cfg_wdata_i;
        vpfd_pkg::CFG_UPPER:      upper_limit_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !front_ready;

  vpfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .up_valid_i    (in_valid_i),
    .up_ready_o    (front_ready),
    .action_i      (action_i),
    .reference_i   (reference_i),
    .measurement_i (measurement_i),
    .dn_valid_o    (front_valid),
    .dn_item_o     (front_item),
    .dn_ready_i    (mult_ready)
  );

  vpfd_mult u_mult (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prop_gain_i     (prop_gain_q),
    .integ_gain_dt_i (integ_gain_dt_q),
    .deriv_gain_i    (deriv_gain_q),
    .up_valid_i      (front_valid),
    .up_ready_o      (mult_ready),
    .up_item_i       (front_item),
    .dn_valid_o      (mult_valid),
    .dn_item_o       (mult_item),
    .dn_ready_i      (deriv_ready)
  );

  vpfd_deriv u_deriv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deriv_pole_i (deriv_pole_q),
    .up_valid_i   (mult_valid),
    .up_ready_o   (deriv_ready),
    .up_item_i    (mult_item),
    .dn_valid_o   (deriv_valid),
    .dn_item_o    (deriv_item),
    .dn_ready_i   (accum_ready)
  );

  vpfd_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lower_limit_i (lower_limit_q),
    .upper_limit_i (upper_limit_q),
    .up_valid_i    (deriv_valid),
    .up_ready_o    (accum_ready),
    .up_item_i     (deriv_item),
    .out_valid_o   (out_valid_o),
    .drive_o       (drive_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

FILE: hdl/vpfd_checker.sv
// Port-level checker for the velocity PID block and its bind.
`timescale 1ns / 1ps

module vpfd_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] drive_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("vpfd: stalled result changed");

  // input backpressure only comes from a stalled, waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("vpfd: input stalled without output backpressure");

  // with the output free, an accepted item passes all stages and raises out_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("vpfd: result missing after pipeline latency");

endmodule

bind velocity_pid_filtered_derivative vpfd_port_checker u_vpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
